// ----- design/pld_pkg.sv -----
// ----------------------------------------------------------------------------
// pld_pkg: shared types and codes for the positional list
// Field widths, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package pld_pkg;

    localparam int DEPTH_DEF       = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 6;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_BADPOS = 2'd1,
        STS_FULL   = 2'd2,
        STS_EMPTY  = 2'd3
    } t_status;

    // What every cell does this cycle.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } t_cell_op;

    // Broadcast to the whole row: operation, target slot, last held slot.
    typedef struct packed {
        t_cell_op          op;
        logic [POS_W-1:0]  k;
        logic [POS_W-1:0]  tail;
    } t_cell_ctrl;

endpackage

// ----- design/pld_req_if.sv -----
// ----------------------------------------------------------------------------
// pld_req_if: request channel of the positional list
// Valid/ready handshake with command, position and value.
// ----------------------------------------------------------------------------
interface pld_req_if import pld_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic [POS_W-1:0]          position;
    logic signed [ITEM_W-1:0]  value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);

endinterface

// ----- design/pld_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pld_rsp_if: response channel of the positional list
// Valid/ready handshake with status, item value, last flag and count.
// ----------------------------------------------------------------------------
interface pld_rsp_if import pld_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [ITEM_W-1:0]  item_value;
    logic                      last;
    logic [COUNT_W-1:0]        count;

    modport source (output valid, output status, output item_value, output last,
                    output count, input ready);
    modport sink   (input valid, input status, input item_value, input last,
                    input count, output ready);

endinterface

// ----- design/positional_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered store with positional insert/delete
// A row of DEPTH cells holds the list; the cells from the target slot on shift together per request.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------
//  i_req    | in  | valid / ready | command, position, value
//  o_rsp    | out | valid / ready | status, item_value, last, count
//
// On insert and delete the cells from the target slot on shift when the
// request is taken, and one response is registered; a bad request only
// registers its response. On dump the row rotates over its held slots,
// the head cell feeding one response per cycle while the response is not
// stalled; after the last one the row is back in order. A new request is
// taken only between operations.
// Reset (synchronous, active low) empties the list; entry storage is not
// cleared. A stalled response holds the row; a request is still taken while
// the response register drains in the same cycle.
// ----------------------------------------------------------------------------
module positional_list_insert_delete import pld_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pld_req_if.sink   i_req,
    pld_rsp_if.source o_rsp
);

    localparam int LEN_W = $clog2(DEPTH + 1);
    // compare width that holds position, length and length + 1
    localparam int CMP_W = (LEN_W + 1 > POS_W) ? LEN_W + 1 : POS_W + 1;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state                    r_state, n_state;
    logic [LEN_W-1:0]          r_len, n_len;
    logic [POS_W-1:0]          r_idx, n_idx;     // dump progress
    logic                      r_valid, n_valid;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic signed [ITEM_W-1:0]  r_item, n_item;
    logic                      r_last, n_last;
    logic [COUNT_W-1:0]        r_count, n_count;

    t_cell_ctrl                w_ctrl;
    logic [VALUE_WIDTH-1:0]    w_val [DEPTH];
    logic [VALUE_WIDTH-1:0]    w_new;
    logic signed [VALUE_WIDTH-1:0] w_head;

    logic                      w_slot;           // response register free
    logic                      w_take;
    logic                      w_full;
    logic                      w_ins_ok;
    logic                      w_del_ok;
    logic [CMP_W-1:0]          w_pos_c;
    logic [CMP_W-1:0]          w_len_c;
    logic [POS_W-1:0]          w_tail;
    logic                      w_dump_last;

    assign w_slot  = !r_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_slot;
    assign w_take  = i_req.valid && i_req.ready;

    assign w_new   = VALUE_WIDTH'(i_req.value);
    assign w_head  = w_val[0];

    assign w_pos_c  = CMP_W'(i_req.position);
    assign w_len_c  = CMP_W'(r_len);
    assign w_full   = (r_len == LEN_W'(DEPTH));
    assign w_ins_ok = (i_req.position != '0) && (w_pos_c <= w_len_c + CMP_W'(1));
    assign w_del_ok = (i_req.position != '0) && (w_pos_c <= w_len_c);
    // only used while the list holds entries
    assign w_tail   = POS_W'(r_len - LEN_W'(1));
    assign w_dump_last = (r_idx == w_tail);

    // ---- the cell row ---------------------------------------------------
    // cell i sees i-1 on the left and i+1 on the right; the head value
    // goes to every cell for the dump rotation
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_new;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign w_right = w_val[g];
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        pld_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX         (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_head),
            .i_new   (w_new),
            .o_val   (w_val[g])
        );
    end

    // ---- sequencing -----------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_idx    = r_idx;
        n_valid  = r_valid && !o_rsp.ready;
        n_status = r_status;
        n_item   = r_item;
        n_last   = r_last;
        n_count  = r_count;
        w_ctrl.op   = CELL_HOLD;
        w_ctrl.k    = i_req.position - POS_W'(1);
        w_ctrl.tail = w_tail;

        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    // single-response default; dump of a non-empty list overrides
                    n_valid  = 1'b1;
                    n_item   = '0;
                    n_last   = 1'b1;
                    n_status = STS_BADPOS;
                    unique case (i_req.command)
                        CMD_INSERT: begin
                            if (w_full) begin
                                n_status = STS_FULL;
                            end else if (w_ins_ok) begin
                                n_status  = STS_OK;
                                w_ctrl.op = CELL_INS;
                                n_len     = r_len + LEN_W'(1);
                            end
                        end
                        CMD_DELETE: begin
                            if (w_del_ok) begin
                                n_status  = STS_OK;
                                w_ctrl.op = CELL_DEL;
                                n_len     = r_len - LEN_W'(1);
                            end
                        end
                        CMD_DUMP: begin
                            if (r_len == '0) begin
                                n_status = STS_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: n_status = STS_BADPOS;
                    endcase
                    n_count = COUNT_W'(n_len);
                end
            end
            S_DUMP: begin
                if (w_slot) begin
                    n_valid   = 1'b1;
                    n_status  = STS_OK;
                    n_item    = ITEM_W'(w_head);
                    n_last    = w_dump_last;
                    n_count   = COUNT_W'(r_len);
                    w_ctrl.op = CELL_ROT;
                    n_idx     = r_idx + POS_W'(1);
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_valid <= n_valid;
        end
        r_idx    <= n_idx;
        r_status <= n_status;
        r_item   <= n_item;
        r_last   <= n_last;
        r_count  <= n_count;
    end

    assign o_rsp.valid      = r_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.item_value = r_item;
    assign o_rsp.last       = r_last;
    assign o_rsp.count      = r_count;

endmodule

// ----- design/pld_cell.sv -----
// ----------------------------------------------------------------------------
// pld_cell: one slot of the list row
// Holds one entry; shifts in from a neighbor on insert, delete and rotate.
// ----------------------------------------------------------------------------
module pld_cell import pld_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int IDX         = 0
) (
    input  logic                   i_clk,
    input  t_cell_ctrl             i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    input  logic [VALUE_WIDTH-1:0] i_head,
    input  logic [VALUE_WIDTH-1:0] i_new,
    output logic [VALUE_WIDTH-1:0] o_val
);

    localparam logic [POS_W-1:0] IDX_V = POS_W'(IDX);

    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] n_val;

    always_comb begin
        n_val = r_val;
        case (i_ctrl.op)
            CELL_INS: begin
                if (IDX_V > i_ctrl.k) begin
                    n_val = i_left;
                end else if (IDX_V == i_ctrl.k) begin
                    n_val = i_new;
                end
            end
            CELL_DEL: begin
                if (IDX_V >= i_ctrl.k) begin
                    n_val = i_right;
                end
            end
            CELL_ROT: begin
                // head wraps to the last held slot
                if (IDX_V == i_ctrl.tail) begin
                    n_val = i_head;
                end else if (IDX_V < i_ctrl.tail) begin
                    n_val = i_right;
                end
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule
